### rtl/core/sparse_poly4_trajectory_recon_assert.svh
// Assertion macros shared by the checker files of this block.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SPARSE_POLY4_TRAJECTORY_RECON_ASSERT_SVH
`define SPARSE_POLY4_TRAJECTORY_RECON_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spt assertion failed");

`endif

### rtl/core/spt_pkg.sv
`timescale 1ns / 1ps
package spt_pkg;

    localparam int VAL_W     = 48;
    localparam int OPD_W     = 49;
    localparam int HALF_W    = 24;
    localparam int PROD_W    = 96;
    localparam int FOCAL_W   = 32;
    localparam int BASE_W    = 33;
    localparam int EXP_W     = 4;
    localparam int EXPS_W    = 16;
    localparam int ORDER_W   = 4;
    localparam int REF_W     = 32;
    localparam int FRAC_BITS = 24;
    localparam int NTAB      = 4;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [OPD_W-1:0]  opd_t;
    typedef logic signed [BASE_W-1:0] base_t;

    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam val_t ONE_FX    = val_t'(ONE_L);
    localparam val_t BRHO_MIN  = val_t'((ONE_L + 500) / 1000);
    localparam val_t LIM_300   = val_t'(300 * ONE_L);
    localparam val_t LIM_2000  = val_t'(2000 * ONE_L);

    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        STAT_ACCEPTED   = 3'd0,
        STAT_REJECTED   = 3'd1,
        STAT_LOADED     = 3'd2,
        STAT_OVER_ORDER = 3'd3,
        STAT_FULL       = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        REG_MAX_ORDER = 1'b0,
        REG_BRHO_REF  = 1'b1
    } reg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_TBL,
        S_RDW,
        S_POW,
        S_POW_WAIT,
        S_APPLY_WAIT,
        S_ACC,
        S_SCALE,
        S_SCALE_WAIT,
        S_RESP
    } state_t;

endpackage

### rtl/core/spt_if.sv
`timescale 1ns / 1ps
interface spt_req_if;
    logic        valid;
    logic        ready;
    logic [0:0]  opcode;
    logic [1:0]  target;
    logic [3:0]  exp_x;
    logic [3:0]  exp_y;
    logic [3:0]  exp_theta;
    logic [3:0]  exp_phi;
    logic signed [47:0] coef_value;
    logic signed [31:0] focal_x;
    logic signed [31:0] focal_y;
    logic signed [31:0] focal_theta;
    logic signed [31:0] focal_phi;

    modport source (output valid, opcode, target, exp_x, exp_y, exp_theta, exp_phi,
                    coef_value, focal_x, focal_y, focal_theta, focal_phi,
                    input ready);
    modport sink (input valid, opcode, target, exp_x, exp_y, exp_theta, exp_phi,
                  coef_value, focal_x, focal_y, focal_theta, focal_phi,
                  output ready);
endinterface

interface spt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic signed [47:0] brho_out;
    logic signed [47:0] theta_out;
    logic signed [47:0] phi_out;
    logic signed [47:0] path_out;

    modport source (output valid, status, brho_out, theta_out, phi_out, path_out,
                    input ready);
    modport sink (input valid, status, brho_out, theta_out, phi_out, path_out,
                  output ready);
endinterface

### rtl/core/spt_ram.sv
`timescale 1ns / 1ps
module spt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/spt_fmul.sv
`timescale 1ns / 1ps
module spt_fmul (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  spt_pkg::opd_t  a,
    input  spt_pkg::opd_t  b,
    output logic           done,
    output spt_pkg::val_t  result
);
    import spt_pkg::*;

    // Magnitudes are split in 24-bit halves and the four partial products
    // are accumulated one per cycle, then rounded and clamped.
    logic [VAL_W-1:0]  ma_reg, mb_reg;
    logic              neg_reg;
    logic              busy_reg;
    logic [2:0]        step_reg;
    logic [PROD_W-1:0] acc_reg;
    logic              done_reg;
    val_t              result_reg;

    opd_t              a_abs, b_abs;
    logic [HALF_W-1:0] opa, opb;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0] pp_shift;
    logic [PROD_W-1:0] rounded;
    logic [PROD_W-FRAC_BITS-1:0] q;
    logic [PROD_W-FRAC_BITS-1:0] lim;
    logic [VAL_W-1:0]  mag;

    always_comb
    begin
        a_abs = a[OPD_W-1] ? -a : a;
        b_abs = b[OPD_W-1] ? -b : b;
        // Steps 0 to 3 take low*low, low*high, high*low and high*high.
        opa = step_reg[1] ? ma_reg[VAL_W-1:HALF_W] : ma_reg[HALF_W-1:0];
        opb = step_reg[0] ? mb_reg[VAL_W-1:HALF_W] : mb_reg[HALF_W-1:0];
        pp = opa * opb;
        case (step_reg)
            3'd0:    pp_shift = PROD_W'(pp);
            3'd3:    pp_shift = PROD_W'(pp) << (2 * HALF_W);
            default: pp_shift = PROD_W'(pp) << HALF_W;
        endcase
        rounded = acc_reg + (PROD_W'(1) << (FRAC_BITS - 1));
        q = rounded[PROD_W-1:FRAC_BITS];
        lim = neg_reg ? (PROD_W-FRAC_BITS)'(1) << (VAL_W - 1)
                      : ((PROD_W-FRAC_BITS)'(1) << (VAL_W - 1)) - 1'b1;
        mag = (q > lim) ? lim[VAL_W-1:0] : q[VAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            ma_reg     <= '0;
            mb_reg     <= '0;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                ma_reg   <= a_abs[VAL_W-1:0];
                mb_reg   <= b_abs[VAL_W-1:0];
                neg_reg  <= a[OPD_W-1] ^ b[OPD_W-1];
                acc_reg  <= '0;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (step_reg == 3'd4)
                begin
                    result_reg <= neg_reg ? -val_t'(mag) : val_t'(mag);
                    done_reg   <= 1'b1;
                    busy_reg   <= 1'b0;
                end
                else
                begin
                    acc_reg  <= acc_reg + pp_shift;
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;
endmodule

### rtl/core/sparse_poly4_trajectory_recon.sv
`timescale 1ns / 1ps
// Channel | Role   | Carries
// cmd     | sink   | load term or evaluate trajectory request
// rsp     | source | status and four 48-bit results, one per request
// cfg     | write  | max_order (index 0), brho_ref (index 1)
//
// A load request is answered through the load state and then the response state.
// An evaluate request walks every stored term of the four tables through one
// shared fixed-point multiplier; a term with exponent sum E takes E+4 products,
// and a final product scales the brho result by brho_ref.
// Reset clears the term counts and sets the configuration to its defaults; the
// term memory is not cleared since only entries below a count are read.
// The block takes no request until the response has been taken by rsp.ready.
module sparse_poly4_trajectory_recon #(
    parameter int TERMS_PER_TABLE = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    spt_req_if.sink     cmd,
    spt_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import spt_pkg::*;

    localparam int DEPTH  = NTAB * TERMS_PER_TABLE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(TERMS_PER_TABLE + 1);
    localparam int WORD_W = VAL_W + EXPS_W;

    state_t state_reg, state_next;

    // Configuration and term counts.
    logic [ORDER_W-1:0] max_order_reg;
    logic [REF_W-1:0]   brho_ref_reg;
    logic [CNT_W-1:0]   cnt_reg [NTAB];

    // Latched request.
    logic [0:0]  opcode_reg;
    logic [1:0]  target_reg;
    logic [EXPS_W-1:0] lexp_reg;
    val_t        coef_reg;
    base_t       x_reg, y_reg, th_reg, ph_reg;

    // Evaluation walk.
    logic [1:0]        t_reg;
    logic [CNT_W-1:0]  c_reg;
    logic [1:0]        vi_reg;
    logic [EXP_W-1:0]  ecnt_reg;
    logic [EXPS_W-1:0] exp_reg;
    val_t              v_reg, p_reg, sum_reg;
    val_t              r_reg [NTAB];
    logic [2:0]        status_reg;

    // Memory and multiplier hookup.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [WORD_W-1:0] ram_wdata, ram_rdata;
    logic              mul_start, mul_done;
    opd_t              mul_a, mul_b;
    val_t              mul_res;

    logic              over_order, table_full;
    base_t             base_sel;
    logic signed [VAL_W:0] sum_wide;
    val_t              sum_sat;
    logic              in_window;

    spt_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    spt_fmul u_fmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .result(mul_res)
    );

    always_comb
    begin
        over_order = (lexp_reg[3:0] > max_order_reg) || (lexp_reg[7:4] > max_order_reg)
                  || (lexp_reg[11:8] > max_order_reg) || (lexp_reg[15:12] > max_order_reg);
        table_full = (cnt_reg[target_reg] == CNT_W'(TERMS_PER_TABLE));
        // Only the phi table sees the focal y and phi; the others take them as zero.
        case (vi_reg)
            2'd0:    base_sel = x_reg;
            2'd1:    base_sel = (t_reg == 2'd2) ? y_reg : '0;
            2'd2:    base_sel = th_reg;
            default: base_sel = (t_reg == 2'd2) ? ph_reg : '0;
        endcase
        sum_wide = {sum_reg[VAL_W-1], sum_reg} + {v_reg[VAL_W-1], v_reg};
        if (sum_wide[VAL_W] != sum_wide[VAL_W-1])
        begin
            sum_sat = sum_wide[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_wide[VAL_W-1:0];
        end
        // The brho window uses the sum before scaling.
        in_window = (r_reg[0] > BRHO_MIN)
                 && (r_reg[1] > -LIM_300) && (r_reg[1] < LIM_300)
                 && (r_reg[2] > -LIM_300) && (r_reg[2] < LIM_300)
                 && (r_reg[3] > val_t'(0)) && (r_reg[3] < LIM_2000);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    state_next = (cmd.opcode == OP_LOAD) ? S_LOAD : S_TBL;
                end
            end
            S_LOAD:   state_next = S_RESP;
            S_TBL:
            begin
                if (c_reg == cnt_reg[t_reg])
                begin
                    state_next = (t_reg == 2'd3) ? S_SCALE : S_TBL;
                end
                else
                begin
                    state_next = S_RDW;
                end
            end
            S_RDW:    state_next = S_POW;
            S_POW:    state_next = (ecnt_reg != '0) ? S_POW_WAIT : S_APPLY_WAIT;
            S_POW_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_POW;
                end
            end
            S_APPLY_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (vi_reg == 2'd3) ? S_ACC : S_POW;
                end
            end
            S_ACC:    state_next = S_TBL;
            S_SCALE:  state_next = S_SCALE_WAIT;
            S_SCALE_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        cmd.ready = (state_reg == S_IDLE);
        rsp.valid = (state_reg == S_RESP);
        ram_we    = (state_reg == S_LOAD) && !over_order && !table_full && (coef_reg != '0);
        ram_waddr = ADDR_W'(target_reg) * ADDR_W'(TERMS_PER_TABLE)
                  + ADDR_W'(cnt_reg[target_reg]);
        ram_wdata = {lexp_reg, coef_reg};
        ram_raddr = ADDR_W'(t_reg) * ADDR_W'(TERMS_PER_TABLE) + ADDR_W'(c_reg);
        mul_start = 1'b0;
        mul_a     = opd_t'(p_reg);
        mul_b     = opd_t'(base_sel);
        case (state_reg)
            S_POW:
            begin
                mul_start = 1'b1;
                if (ecnt_reg == '0)
                begin
                    mul_a = opd_t'(v_reg);
                    mul_b = opd_t'(p_reg);
                end
            end
            S_SCALE:
            begin
                mul_start = 1'b1;
                mul_a     = opd_t'(r_reg[0]);
                mul_b     = opd_t'({1'b0, brho_ref_reg});
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign rsp.status    = status_reg;
    assign rsp.brho_out  = r_reg[0];
    assign rsp.theta_out = r_reg[1];
    assign rsp.phi_out   = r_reg[2];
    assign rsp.path_out  = r_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            max_order_reg <= ORDER_W'(7);
            brho_ref_reg  <= REF_W'(ONE_L);
            for (int i = 0; i < NTAB; i++)
            begin
                cnt_reg[i] <= '0;
                r_reg[i]   <= '0;
            end
            opcode_reg <= '0;
            target_reg <= '0;
            lexp_reg   <= '0;
            coef_reg   <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            th_reg     <= '0;
            ph_reg     <= '0;
            t_reg      <= '0;
            c_reg      <= '0;
            vi_reg     <= '0;
            ecnt_reg   <= '0;
            exp_reg    <= '0;
            v_reg      <= '0;
            p_reg      <= '0;
            sum_reg    <= '0;
            status_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                if (cfg_index == REG_MAX_ORDER)
                begin
                    max_order_reg <= cfg_data[ORDER_W-1:0];
                    for (int i = 0; i < NTAB; i++)
                    begin
                        cnt_reg[i] <= '0;
                    end
                end
                else
                begin
                    brho_ref_reg <= cfg_data[REF_W-1:0];
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        opcode_reg <= cmd.opcode;
                        target_reg <= cmd.target;
                        lexp_reg   <= {cmd.exp_phi, cmd.exp_theta, cmd.exp_y, cmd.exp_x};
                        coef_reg   <= cmd.coef_value;
                        x_reg      <= -base_t'(cmd.focal_x);
                        y_reg      <= -base_t'(cmd.focal_y);
                        th_reg     <= -base_t'(cmd.focal_theta);
                        ph_reg     <= -base_t'(cmd.focal_phi);
                        t_reg      <= '0;
                        c_reg      <= '0;
                        sum_reg    <= '0;
                        for (int i = 0; i < NTAB; i++)
                        begin
                            r_reg[i] <= '0;
                        end
                    end
                end
                S_LOAD:
                begin
                    if (over_order)
                    begin
                        status_reg <= STAT_OVER_ORDER;
                    end
                    else if (table_full)
                    begin
                        status_reg <= STAT_FULL;
                    end
                    else
                    begin
                        status_reg <= STAT_LOADED;
                        if (coef_reg != '0)
                        begin
                            cnt_reg[target_reg] <= cnt_reg[target_reg] + 1'b1;
                        end
                    end
                end
                S_TBL:
                begin
                    if (c_reg == cnt_reg[t_reg])
                    begin
                        r_reg[t_reg] <= sum_reg;
                        sum_reg      <= '0;
                        c_reg        <= '0;
                        t_reg        <= t_reg + 2'd1;
                    end
                end
                S_RDW:
                begin
                    v_reg    <= ram_rdata[VAL_W-1:0];
                    exp_reg  <= ram_rdata[WORD_W-1:VAL_W];
                    ecnt_reg <= ram_rdata[VAL_W+EXP_W-1:VAL_W];
                    vi_reg   <= '0;
                    p_reg    <= ONE_FX;
                end
                S_POW_WAIT:
                begin
                    if (mul_done)
                    begin
                        p_reg    <= mul_res;
                        ecnt_reg <= ecnt_reg - 1'b1;
                    end
                end
                S_APPLY_WAIT:
                begin
                    if (mul_done)
                    begin
                        v_reg    <= mul_res;
                        vi_reg   <= vi_reg + 2'd1;
                        p_reg    <= ONE_FX;
                        ecnt_reg <= exp_reg[(vi_reg + 2'd1) * EXP_W +: EXP_W];
                    end
                end
                S_ACC:
                begin
                    sum_reg <= sum_sat;
                    c_reg   <= c_reg + 1'b1;
                end
                S_SCALE:
                begin
                    status_reg <= in_window ? STAT_ACCEPTED : STAT_REJECTED;
                end
                S_SCALE_WAIT:
                begin
                    if (mul_done)
                    begin
                        r_reg[0] <= mul_res;
                    end
                end
                default:
                begin
                    opcode_reg <= opcode_reg;
                end
            endcase
        end
    end
endmodule

### rtl/core/spt_checker.sv
`timescale 1ns / 1ps
`include "sparse_poly4_trajectory_recon_assert.svh"
module spt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] rsp_status
);
    // A pending response and a free request side never coexist.
    `SPT_ASSERT_SAME(a_resp_blocks_req, rsp_valid, !cmd_ready)
    // An accepted request keeps the block busy in the following cycle.
    `SPT_ASSERT_NEXT(a_busy_after_req, cmd_valid && cmd_ready, !cmd_ready)
    // A stalled response stays offered.
    `SPT_ASSERT_NEXT(a_resp_held, rsp_valid && !rsp_ready, rsp_valid)
    // Only the five defined status codes are ever shown.
    `SPT_ASSERT_SAME(a_status_legal, rsp_valid, rsp_status <= 3'd4)
endmodule

bind sparse_poly4_trajectory_recon spt_checker u_spt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_status(rsp.status)
);
